FILE: hw/rtl/mdu_pkg.sv
// Shared widths, constants and payload types of the modular division unit.
`timescale 1ns / 1ps
`default_nettype none

package mdu_pkg;

	localparam int unsigned WIDTH = 31;
	// counter bits: enough to index every bit of an operand
	localparam int unsigned KW = $clog2(WIDTH);
	localparam int unsigned TOP_BIT = WIDTH - 1;
	localparam logic [KW-1:0] K_TOP = TOP_BIT[KW-1:0];
	localparam logic [WIDTH-1:0] VAL_ONE = {{(WIDTH-1){1'b0}}, 1'b1};

	typedef struct packed {
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
		logic [WIDTH-1:0] modulus;
	} mdu_in_t;

	typedef struct packed {
		logic [WIDTH-1:0] quotient;
		logic             defined;
	} mdu_out_t;

	typedef struct packed {
		logic idle;
		logic done;
	} mdu_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mdu_modadd.sv
// Shared modular adder: (x + y) mod m for x, y below m.
`timescale 1ns / 1ps
`default_nettype none

module mdu_modadd (
	input  wire logic [mdu_pkg::WIDTH-1:0] x,
	input  wire logic [mdu_pkg::WIDTH-1:0] y,
	input  wire logic [mdu_pkg::WIDTH-1:0] m,
	output logic      [mdu_pkg::WIDTH-1:0] sum
);

	logic [mdu_pkg::WIDTH:0] raw;
	logic [mdu_pkg::WIDTH:0] red;

	assign raw = {1'b0, x} + {1'b0, y};
	assign red = raw - {1'b0, m};
	// fold back once: the raw sum stays below twice the modulus
	assign sum = (raw >= {1'b0, m}) ? red[mdu_pkg::WIDTH-1:0] : raw[mdu_pkg::WIDTH-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/mdu_core.sv
// Sequencer and datapath registers of the modular division unit.
`timescale 1ns / 1ps
`default_nettype none

module mdu_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire mdu_pkg::mdu_in_t  op,
	input  wire logic              take,
	output mdu_pkg::mdu_stat_t     stat,
	output mdu_pkg::mdu_out_t      res
);

	localparam int unsigned W = mdu_pkg::WIDTH;
	localparam int unsigned KW = mdu_pkg::KW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALIGN,
		S_STEPA,
		S_STEPB,
		S_NEG,
		S_UPD,
		S_ECHK,
		S_DONE
	} state_t;

	// what the current shift-subtract run is for
	typedef enum logic [1:0] {
		JOB_DVS,
		JOB_EUC,
		JOB_DVD,
		JOB_MUL
	} job_t;

	state_t state_q;
	job_t   job_q;

	logic [W-1:0]  r0_q;
	logic [W-1:0]  r1_q;
	logic [W-1:0]  t0_q;
	logic [W-1:0]  t1_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  m_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  d_q;
	logic [KW-1:0] k_q;
	logic          def_q;

	logic          ge;
	logic [W-1:0]  rsub;
	logic          shl_fits;
	logic          cur_bit;
	logic          need_b;
	logic          adv;
	logic [W-1:0]  rem_nx;
	logic [W-1:0]  ma_x;
	logic [W-1:0]  ma_y;
	logic [W-1:0]  ma_sum;

	assign ge       = (r0_q >= d_q);
	assign rsub     = r0_q - d_q;
	assign shl_fits = ({d_q, 1'b0} <= {1'b0, r0_q});
	assign cur_bit  = (job_q == JOB_MUL) ? r0_q[k_q] : ge;
	assign need_b   = cur_bit && ((job_q == JOB_EUC) || (job_q == JOB_MUL));
	assign adv      = ((state_q == S_STEPA) && !need_b) || (state_q == S_STEPB);
	assign rem_nx   = ((state_q == S_STEPA) && (job_q != JOB_MUL) && ge) ? rsub : r0_q;

	always_comb begin
		unique case (state_q)
			S_STEPB: begin
				ma_x = acc_q;
				ma_y = (job_q == JOB_MUL) ? t0_q : t1_q;
			end
			S_UPD: begin
				ma_x = t0_q;
				ma_y = acc_q;
			end
			default: begin
				ma_x = acc_q;
				ma_y = acc_q;
			end
		endcase
	end

	mdu_modadd u_modadd (
		.x   (ma_x),
		.y   (ma_y),
		.m   (m_q),
		.sum (ma_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= JOB_DVS;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (op.modulus == '0) begin
							acc_q   <= '0;
							def_q   <= 1'b0;
							state_q <= S_DONE;
						end else begin
							m_q     <= op.modulus;
							dvd_q   <= op.dividend;
							r0_q    <= op.divisor;
							d_q     <= op.modulus;
							k_q     <= '0;
							acc_q   <= '0;
							job_q   <= JOB_DVS;
							state_q <= S_ALIGN;
						end
					end
				end
				S_ALIGN: begin
					if (shl_fits) begin
						d_q <= {d_q[W-2:0], 1'b0};
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_STEPA;
					end
				end
				S_STEPA: begin
					r0_q  <= rem_nx;
					acc_q <= ma_sum;
					if (need_b) begin
						state_q <= S_STEPB;
					end
				end
				S_STEPB: begin
					acc_q <= ma_sum;
				end
				S_NEG: begin
					acc_q   <= m_q - acc_q;
					state_q <= S_UPD;
				end
				S_UPD: begin
					t1_q    <= ma_sum;
					t0_q    <= t1_q;
					r0_q    <= r1_q;
					r1_q    <= r0_q;
					state_q <= S_ECHK;
				end
				S_ECHK: begin
					if (r1_q == '0) begin
						if (r0_q == mdu_pkg::VAL_ONE) begin
							r0_q    <= dvd_q;
							d_q     <= m_q;
							k_q     <= '0;
							job_q   <= JOB_DVD;
							state_q <= S_ALIGN;
						end else begin
							acc_q   <= '0;
							def_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end else begin
						d_q     <= r1_q;
						k_q     <= '0;
						acc_q   <= '0;
						job_q   <= JOB_EUC;
						state_q <= S_ALIGN;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// advance to the next bit, or close the current run
			if (adv) begin
				if (k_q != '0) begin
					k_q     <= k_q - 1'b1;
					d_q     <= {1'b0, d_q[W-1:1]};
					state_q <= S_STEPA;
				end else begin
					unique case (job_q)
						JOB_DVS: begin
							r1_q    <= rem_nx;
							r0_q    <= m_q;
							t0_q    <= '0;
							t1_q    <= (m_q == mdu_pkg::VAL_ONE) ? '0 : mdu_pkg::VAL_ONE;
							state_q <= S_ECHK;
						end
						JOB_EUC: begin
							state_q <= S_NEG;
						end
						JOB_DVD: begin
							acc_q   <= '0;
							k_q     <= mdu_pkg::K_TOP;
							job_q   <= JOB_MUL;
							state_q <= S_STEPA;
						end
						JOB_MUL: begin
							def_q   <= 1'b1;
							state_q <= S_DONE;
						end
					endcase
				end
			end
		end
	end

	assign stat.idle    = (state_q == S_IDLE);
	assign stat.done    = (state_q == S_DONE);
	assign res.quotient = acc_q;
	assign res.defined  = def_q;

endmodule

`default_nettype wire

FILE: hw/rtl/modular_division_unit_top.sv
// Top level of the modular division unit: handshakes and result register.
//
// Computes quotient = dividend * divisor^-1 mod modulus, with defined set when
// divisor and modulus are coprime; otherwise quotient is 0 and defined is 0.
// A modulus of zero gives an undefined result at once.
// Input channel in_valid/in_ready carries dividend, divisor and modulus; output
// channel out_valid/out_ready carries quotient and defined. One result per item.
// One item is worked at a time on a shared modular adder and one
// compare/subtract unit: reduce divisor mod modulus, run extended Euclid with
// shift-subtract division whose quotient bits feed the Bezout update, reduce
// the dividend, then a bit-serial modular multiply. Each division first
// shifts the divisor into alignment, then works through the quotient bits
// one by one; each Euclid round then negates and updates the coefficients
// and checks for the end, and the final multiply adds the inverse for each
// set bit of the reduced dividend. in_ready is high only while the sequencer
// is idle, so one item finishes before the next is taken.
// A finished result moves to the output register; a stalled receiver holds it
// there while the next item is already taken. The sequencer waits in its done
// state only if the output register is still full. Reset idles the sequencer
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module modular_division_unit_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire mdu_pkg::mdu_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mdu_pkg::mdu_out_t     out_data
);

	mdu_pkg::mdu_stat_t stat;
	mdu_pkg::mdu_out_t  core_res;
	mdu_pkg::mdu_out_t  out_data_q;
	logic               out_valid_q;
	logic               start;
	logic               take;

	// accept a transfer only while the sequencer is free
	assign in_ready = stat.idle;
	assign start    = in_valid && in_ready;
	// move the result once the output slot is empty or drains this cycle
	assign take     = stat.done && (!out_valid_q || out_ready);

	mdu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (in_data),
		.take   (take),
		.stat   (stat),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until the receiver completes the transfer
	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= core_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
